/* hdl/dhec_pkg.sv */
// Shared widths, reset values, codes and types of the dual hysteresis encoder counter.
package dhec_pkg;

  localparam int SampleWidth   = 10;
  localparam int CountWidth    = 32;
  localparam int CfgIndexWidth = 3;

  localparam logic [SampleWidth-1:0] LeftHighReset  = SampleWidth'(64);
  localparam logic [SampleWidth-1:0] LeftLowReset   = SampleWidth'(50);
  localparam logic [SampleWidth-1:0] RightHighReset = SampleWidth'(62);
  localparam logic [SampleWidth-1:0] RightLowReset  = SampleWidth'(48);

  localparam logic [CfgIndexWidth-1:0] RegLeftHigh  = CfgIndexWidth'(0);
  localparam logic [CfgIndexWidth-1:0] RegLeftLow   = CfgIndexWidth'(1);
  localparam logic [CfgIndexWidth-1:0] RegRightHigh = CfgIndexWidth'(2);
  localparam logic [CfgIndexWidth-1:0] RegRightLow  = CfgIndexWidth'(3);

  localparam logic OpCount = 1'b0;
  localparam logic OpReset = 1'b1;

  typedef struct packed {
    logic [SampleWidth-1:0] high;
    logic [SampleWidth-1:0] low;
  } thresh_t;

endpackage

/* hdl/dhec_cfg_regs.sv */
// Threshold register file written through the configuration request channel.
module dhec_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [dhec_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [dhec_pkg::SampleWidth-1:0]    cfg_data,
  output dhec_pkg::thresh_t                   left_thresh,
  output dhec_pkg::thresh_t                   right_thresh
);

  always_ff @(posedge clk) begin
    if (rst) begin
      left_thresh.high  <= dhec_pkg::LeftHighReset;
      left_thresh.low   <= dhec_pkg::LeftLowReset;
      right_thresh.high <= dhec_pkg::RightHighReset;
      right_thresh.low  <= dhec_pkg::RightLowReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dhec_pkg::RegLeftHigh:  left_thresh.high  <= cfg_data;
        dhec_pkg::RegLeftLow:   left_thresh.low   <= cfg_data;
        dhec_pkg::RegRightHigh: right_thresh.high <= cfg_data;
        dhec_pkg::RegRightLow:  right_thresh.low  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* hdl/dhec_channel.sv */
// One wheel channel: hysteresis level flag and wrapping transition count.
module dhec_channel (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  logic                                op,
  input  logic [dhec_pkg::SampleWidth-1:0]    sample,
  input  logic                                forward,
  input  dhec_pkg::thresh_t                   thresh,
  output logic [dhec_pkg::CountWidth-1:0]     count_next,
  output logic                                tick_next
);

  logic                               level_low;
  logic                               level_low_next;
  logic [dhec_pkg::CountWidth-1:0]    total;
  logic [dhec_pkg::SampleWidth:0]     mid;
  logic                               above_mid;
  logic                               change;

  always_comb begin
    mid       = ({1'b0, thresh.high} + {1'b0, thresh.low}) >> 1;
    above_mid = {1'b0, sample} > mid;
    change    = level_low ? (sample > thresh.high) : (sample < thresh.low);
    if (op == dhec_pkg::OpReset) begin
      level_low_next = !above_mid;
      count_next     = '0;
      tick_next      = 1'b0;
    end else begin
      level_low_next = change ? !level_low : level_low;
      tick_next      = change;
      if (!change) begin
        count_next = total;
      end else if (forward) begin
        count_next = total + dhec_pkg::CountWidth'(1);
      end else begin
        count_next = total - dhec_pkg::CountWidth'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_low <= 1'b0;
      total     <= '0;
    end else if (advance) begin
      level_low <= level_low_next;
      total     <= count_next;
    end
  end

endmodule

/* hdl/dual_hysteresis_encoder_counter_unit.sv */
// Top level of the dual hysteresis wheel encoder counter.
// A request passes the input register, then the result register; while out_ready holds
// a result back, the next request waits in the input register.
// Throughput: one request per cycle; the single compare-and-increment pass sets it.
// A stalled result register stalls the input register, which then holds in_ready low.
// Synchronous reset empties both stages, clears levels and counts, restores thresholds.
module dual_hysteresis_encoder_counter_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                op,
  input  logic [dhec_pkg::SampleWidth-1:0]    left_sample,
  input  logic [dhec_pkg::SampleWidth-1:0]    right_sample,
  input  logic                                left_forward,
  input  logic                                right_forward,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [dhec_pkg::CountWidth-1:0] left_count,
  output logic signed [dhec_pkg::CountWidth-1:0] right_count,
  output logic                                left_tick,
  output logic                                right_tick,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dhec_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [dhec_pkg::SampleWidth-1:0]    cfg_data
);

  dhec_pkg::thresh_t                  left_thresh;
  dhec_pkg::thresh_t                  right_thresh;

  logic                               s1_valid;
  logic                               s1_op;
  logic [dhec_pkg::SampleWidth-1:0]   s1_left_sample;
  logic [dhec_pkg::SampleWidth-1:0]   s1_right_sample;
  logic                               s1_left_forward;
  logic                               s1_right_forward;

  logic                               advance;
  logic [dhec_pkg::CountWidth-1:0]    left_count_next;
  logic [dhec_pkg::CountWidth-1:0]    right_count_next;
  logic                               left_tick_next;
  logic                               right_tick_next;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;

  dhec_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .left_thresh  (left_thresh),
    .right_thresh (right_thresh)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op            <= op;
      s1_left_sample   <= left_sample;
      s1_right_sample  <= right_sample;
      s1_left_forward  <= left_forward;
      s1_right_forward <= right_forward;
    end
  end

  dhec_channel u_left (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .op         (s1_op),
    .sample     (s1_left_sample),
    .forward    (s1_left_forward),
    .thresh     (left_thresh),
    .count_next (left_count_next),
    .tick_next  (left_tick_next)
  );

  dhec_channel u_right (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .op         (s1_op),
    .sample     (s1_right_sample),
    .forward    (s1_right_forward),
    .thresh     (right_thresh),
    .count_next (right_count_next),
    .tick_next  (right_tick_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      left_count  <= left_count_next;
      right_count <= right_count_next;
      left_tick   <= left_tick_next;
      right_tick  <= right_tick_next;
    end
  end

endmodule

/* hdl/dhec_checker.sv */
// Port-level checks for the dual hysteresis encoder counter, bound to the top level.
module dhec_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                op,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [dhec_pkg::CountWidth-1:0] left_count,
  input  logic signed [dhec_pkg::CountWidth-1:0] right_count,
  input  logic                                left_tick,
  input  logic                                right_tick
);

  // nothing survives reset in the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(left_count) && $stable(right_count)
      && $stable(left_tick) && $stable(right_tick))
    else $error("stalled result changed");

  // a reset request, once the result side is ready, reaches the output with zeroed counts
  a_reset_op: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && op == dhec_pkg::OpReset) ##1 out_ready |=>
      out_valid && left_count == '0 && right_count == '0 && !left_tick && !right_tick)
    else $error("reset request did not clear counts");

  // with the output free, the input side never backs up
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind dual_hysteresis_encoder_counter_unit dhec_checker u_dhec_checker (.*);

/* dv/dual_hysteresis_encoder_counter_unit_checker.sv */
// Checker for the dual hysteresis encoder counter: tracks thresholds, predicts and compares.
module dual_hysteresis_encoder_counter_unit_checker
  import dhec_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          op,
  input  logic [SampleWidth-1:0]        left_sample,
  input  logic [SampleWidth-1:0]        right_sample,
  input  logic                          left_forward,
  input  logic                          right_forward,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [CountWidth-1:0]  left_count,
  input  logic signed [CountWidth-1:0]  right_count,
  input  logic                          left_tick,
  input  logic                          right_tick,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [CfgIndexWidth-1:0]      cfg_index,
  input  logic [SampleWidth-1:0]        cfg_data,
  output int                            errors,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [CountWidth-1:0] left_count;
    logic signed [CountWidth-1:0] right_count;
    logic                         left_tick;
    logic                         right_tick;
  } wheel_counts_t;

  thresh_t               thr       [2];
  logic                  level_low [2];
  logic [CountWidth-1:0] total     [2];
  wheel_counts_t         expected_counts [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // index 0 is the left wheel, 1 the right
  function automatic wheel_counts_t predict_counts(logic op_i,
                                                   logic [SampleWidth-1:0] ls,
                                                   logic [SampleWidth-1:0] rs,
                                                   logic lf, logic rf);
    logic [SampleWidth-1:0] smp  [2];
    logic                   fwd  [2];
    logic                   tick [2];
    logic [SampleWidth:0]   mid;
    wheel_counts_t          res;
    smp = '{ls, rs};
    fwd = '{lf, rf};
    for (int ch = 0; ch < 2; ch++) begin
      tick[ch] = 1'b0;
      if (op_i == OpReset) begin
        mid           = ({1'b0, thr[ch].high} + {1'b0, thr[ch].low}) >> 1;
        total[ch]     = '0;
        level_low[ch] = !({1'b0, smp[ch]} > mid);
      end else if (level_low[ch] ? (smp[ch] > thr[ch].high) : (smp[ch] < thr[ch].low)) begin
        level_low[ch] = !level_low[ch];
        tick[ch]      = 1'b1;
        total[ch]     = fwd[ch] ? total[ch] + 1'b1 : total[ch] - 1'b1;
      end
    end
    res.left_count  = total[0];
    res.right_count = total[1];
    res.left_tick   = tick[0];
    res.right_tick  = tick[1];
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    wheel_counts_t want;
    if (rst) begin
      thr[0]    = '{high: LeftHighReset, low: LeftLowReset};
      thr[1]    = '{high: RightHighReset, low: RightLowReset};
      level_low = '{1'b0, 1'b0};
      total     = '{'0, '0};
      expected_counts.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegLeftHigh:  thr[0].high = cfg_data;
          RegLeftLow:   thr[0].low  = cfg_data;
          RegRightHigh: thr[1].high = cfg_data;
          RegRightLow:  thr[1].low  = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_counts.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          want = expected_counts.pop_front();
          if (left_count !== want.left_count) begin
            $error("left_count: expected %0d, got %0d", want.left_count, left_count);
            errors++;
          end
          if (right_count !== want.right_count) begin
            $error("right_count: expected %0d, got %0d", want.right_count, right_count);
            errors++;
          end
          if (left_tick !== want.left_tick) begin
            $error("left_tick: expected %0b, got %0b", want.left_tick, left_tick);
            errors++;
          end
          if (right_tick !== want.right_tick) begin
            $error("right_tick: expected %0b, got %0b", want.right_tick, right_tick);
            errors++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_counts.push_back(predict_counts(op, left_sample, right_sample,
                                                 left_forward, right_forward));
    end
    pending = expected_counts.size();
  end

endmodule

/* dv/dual_hysteresis_encoder_counter_unit_test.sv */
// Stimulus, clock, reset and verdict for the dual hysteresis encoder counter.
module dual_hysteresis_encoder_counter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dhec_pkg::*;

  localparam int CycleLimit   = 300000;
  localparam int BatchLength  = 190;
  localparam int HoldOffCycles = 60;

  typedef struct packed {
    logic                   op;
    logic [SampleWidth-1:0] ls;
    logic [SampleWidth-1:0] rs;
    logic                   lf;
    logic                   rf;
  } wheel_request_t;

  // default thresholds: left 64/50 (midpoint 57), right 62/48 (midpoint 55)
  localparam wheel_request_t OpeningRequests [16] = '{
    '{OpCount, 10'd0,    10'd0,    1'b0, 1'b0},
    '{OpCount, 10'd64,   10'd62,   1'b1, 1'b1},
    '{OpCount, 10'd65,   10'd63,   1'b1, 1'b1},
    '{OpCount, 10'd50,   10'd48,   1'b0, 1'b0},
    '{OpCount, 10'd49,   10'd47,   1'b1, 1'b0},
    '{OpCount, 10'd1023, 10'd1023, 1'b0, 1'b1},
    '{OpCount, 10'd1023, 10'd0,    1'b1, 1'b0},
    '{OpReset, 10'd57,   10'd55,   1'b1, 1'b1},
    '{OpCount, 10'd57,   10'd55,   1'b0, 1'b1},
    '{OpReset, 10'd58,   10'd56,   1'b0, 1'b0},
    '{OpCount, 10'd0,    10'd1023, 1'b0, 1'b1},
    '{OpReset, 10'd0,    10'd1023, 1'b1, 1'b0},
    '{OpCount, 10'd1023, 10'd0,    1'b1, 1'b1},
    '{OpReset, 10'd1023, 10'd0,    1'b0, 1'b1},
    '{OpCount, 10'd0,    10'd0,    1'b0, 1'b0},
    '{OpCount, 10'd0,    10'd1023, 1'b1, 1'b1}
  };

  logic                         clk;
  logic                         rst           = 1'b1;
  logic                         in_valid      = 1'b0;
  logic                         in_ready;
  logic                         op            = OpCount;
  logic [SampleWidth-1:0]       left_sample   = '0;
  logic [SampleWidth-1:0]       right_sample  = '0;
  logic                         left_forward  = 1'b0;
  logic                         right_forward = 1'b0;
  logic                         out_valid;
  logic                         out_ready     = 1'b0;
  logic signed [CountWidth-1:0] left_count;
  logic signed [CountWidth-1:0] right_count;
  logic                         left_tick;
  logic                         right_tick;
  logic                         cfg_valid     = 1'b0;
  logic                         cfg_ready;
  logic [CfgIndexWidth-1:0]     cfg_index     = '0;
  logic [SampleWidth-1:0]       cfg_data      = '0;

  int      errors;
  int      pending;
  int      cycle_count        = 0;
  int      sender_idle_pct    = 0;
  int      receiver_stall_pct = 0;
  logic    hold_req           = 1'b0;
  thresh_t lthr               = '{high: LeftHighReset, low: LeftLowReset};
  thresh_t rthr               = '{high: RightHighReset, low: RightLowReset};

  dual_hysteresis_encoder_counter_unit dut (.*);
  dual_hysteresis_encoder_counter_unit_checker checker_inst (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("dual_hysteresis_encoder_counter_unit: mismatch");
      $finish;
    end
  end

  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // entered and left at a falling edge; valid stays high for a back-to-back request
  task automatic offer_item(wheel_request_t req);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    op            <= req.op;
    left_sample   <= req.ls;
    right_sample  <= req.rs;
    left_forward  <= req.lf;
    right_forward <= req.rf;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIndexWidth-1:0] idx, logic [SampleWidth-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // mostly samples near the switching points so that the levels keep crossing
  function automatic logic [SampleWidth-1:0] pick_sample(thresh_t th);
    logic [SampleWidth-1:0] offs;
    offs = SampleWidth'($urandom_range(4)) - SampleWidth'(2);
    case ($urandom_range(9))
      0, 1:    return SampleWidth'($urandom);
      2, 3, 4: return th.high + offs;
      5, 6, 7: return th.low + offs;
      8:       return $urandom_range(1) ? '1 : '0;
      default: return SampleWidth'(({1'b0, th.high} + {1'b0, th.low}) >> 1) + offs;
    endcase
  endfunction

  initial begin : stimulus
    int             k;
    int             lo_val;
    int             hi_val;
    wheel_request_t req;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (OpeningRequests[i]) offer_item(OpeningRequests[i]);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 57; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 57; end
        default: begin sender_idle_pct = 10; receiver_stall_pct = 10; end
      endcase
      for (int s = 0; s < 2; s++) begin
        wait_drain();
        k = phase * 2 + s;
        case (k)
          0: begin lthr = '{'0, '0}; rthr = '{'0, '0}; end
          1: begin lthr = '{'1, '1}; rthr = '{'1, '1}; end
          2: begin lthr = '{'1, '0}; rthr = '{'0, '1}; end
          3, 6: begin
            lo_val = $urandom_range(900);
            hi_val = lo_val + $urandom_range(1, 123);
            lthr   = '{SampleWidth'(hi_val), SampleWidth'(lo_val)};
            lo_val = $urandom_range(900);
            hi_val = lo_val + $urandom_range(1, 123);
            rthr   = '{SampleWidth'(hi_val), SampleWidth'(lo_val)};
          end
          4: begin
            // crossed: low above high
            hi_val = $urandom_range(900);
            lo_val = hi_val + $urandom_range(1, 123);
            lthr   = '{SampleWidth'(hi_val), SampleWidth'(lo_val)};
            hi_val = $urandom_range(900);
            lo_val = hi_val + $urandom_range(1, 123);
            rthr   = '{SampleWidth'(hi_val), SampleWidth'(lo_val)};
          end
          default: begin
            lthr = '{SampleWidth'($urandom), SampleWidth'($urandom)};
            rthr = '{SampleWidth'($urandom), SampleWidth'($urandom)};
          end
        endcase
        write_reg(RegLeftHigh, lthr.high);
        write_reg(RegLeftLow, lthr.low);
        write_reg(RegRightHigh, rthr.high);
        write_reg(RegRightLow, rthr.low);
        // unmapped index must leave every threshold alone
        write_reg(RegRightLow + CfgIndexWidth'($urandom_range(1, 4)), SampleWidth'($urandom));
        cfg_valid <= 1'b0;
        for (int n = 0; n < BatchLength; n++) begin
          if (s == 0 && n == 40 && phase % 2 == 0) hold_req = 1'b1;
          req.op = ($urandom_range(99) < 4) ? OpReset : OpCount;
          req.ls = pick_sample(lthr);
          req.rs = pick_sample(rthr);
          req.lf = 1'($urandom);
          req.rf = 1'($urandom);
          offer_item(req);
        end
      end
    end

    wait_drain();
    repeat (4) @(negedge clk);
    if (errors == 0) begin
      $display("dual_hysteresis_encoder_counter_unit: match");
    end else begin
      $display("dual_hysteresis_encoder_counter_unit: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/dhec_pkg.sv
hdl/dhec_cfg_regs.sv
hdl/dhec_channel.sv
hdl/dual_hysteresis_encoder_counter_unit.sv
hdl/dhec_checker.sv
dv/dual_hysteresis_encoder_counter_unit_checker.sv
dv/dual_hysteresis_encoder_counter_unit_test.sv
